// File: hdl/spq_pkg.sv
// Package for the sorted priority queue: field widths, codes, entry and result types.
// No dependencies; the interfaces, the top level, the checker and the bench use it.
`default_nettype none

package spq_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned HANDLE_W     = 16;
  localparam int unsigned OFFSET_W     = 16;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned FILL_W       = 5;

  typedef enum logic {
    FUNC_INSERT  = 1'b0,
    FUNC_DEQUEUE = 1'b1
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [HANDLE_W-1:0]     payload;
    logic [OFFSET_W-1:0]     offset;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic                    out_valid;
    logic signed [KEY_W-1:0] out_key;
    logic [HANDLE_W-1:0]     out_payload;
    logic [OFFSET_W-1:0]     out_offset;
    logic [STATUS_W-1:0]     status;
    logic [FILL_W-1:0]       fill_count;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/spq_if.sv
// Request and result channel interfaces of the sorted priority queue.
// Depends on spq_pkg for field widths.
`default_nettype none

interface spq_in_if;
  logic                             valid;
  logic                             ready;
  logic                             func;
  logic signed [spq_pkg::KEY_W-1:0] sort_key;
  logic [spq_pkg::HANDLE_W-1:0]     payload_handle;
  logic [spq_pkg::OFFSET_W-1:0]     item_offset;

  modport source (output valid, func, sort_key, payload_handle, item_offset, input ready);
  modport sink   (input valid, func, sort_key, payload_handle, item_offset, output ready);
endinterface

interface spq_out_if;
  logic                             valid;
  logic                             ready;
  logic                             out_valid;
  logic signed [spq_pkg::KEY_W-1:0] out_key;
  logic [spq_pkg::HANDLE_W-1:0]     out_payload;
  logic [spq_pkg::OFFSET_W-1:0]     out_offset;
  logic [spq_pkg::STATUS_W-1:0]     status;
  logic [spq_pkg::FILL_W-1:0]       fill_count;

  modport source (output valid, out_valid, out_key, out_payload, out_offset, status,
                  fill_count, input ready);
  modport sink   (input valid, out_valid, out_key, out_payload, out_offset, status,
                  fill_count, output ready);
endinterface

`default_nettype wire

// File: hdl/spq_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module spq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: hdl/sorted_priority_queue_unit.sv
// Sorted priority queue, top level: circular entry RAM, head/count registers, sequencer.
// Depends on spq_pkg, spq_if and spq_ram.
// Dequeue: the head entry is read from the RAM, taken into the result register in S_DEQ
//   and moved to the output register in S_RESP. Insert: moves up every entry with a key
//   not smaller than the new one (one RAM read, one key compare and one RAM write per
//   cycle over the scan from the tail). Insert into an empty or a full queue and dequeue
//   from an empty one go straight to S_RESP. The next request is taken the cycle after
//   the result is loaded, later while the result is stalled; reset empties the queue.
`default_nettype none

module sorted_priority_queue_unit #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  spq_in_if.sink     in_i,
  spq_out_if.source  out_o
);

  import spq_pkg::*;

  localparam int unsigned ADDR_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_INS_CMP = 5'b00010,
    S_INS_PUT = 5'b00100,
    S_DEQ     = 5'b01000,
    S_RESP    = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [ADDR_W-1:0]   idx_q, idx_d;
  entry_t              new_q, new_d;
  result_t             res_q, res_d;
  result_t             out_q, out_d;
  logic                oval_q, oval_d;

  logic                we;
  logic [ADDR_W-1:0]   waddr, raddr;
  entry_t              wdata;
  logic [ENTRY_W-1:0]  rdata_raw;
  entry_t              rdata;
  entry_t              in_entry;
  logic [ADDR_W-1:0]   cnt_last;
  logic [ADDR_W-1:0]   head_inc;
  logic                key_less;
  logic [CNT_W-1:0]    cnt_inc, cnt_dec;

  // logical slot -> RAM address, sum stays below twice the capacity
  function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] head,
                                             input logic [ADDR_W-1:0] slot);
    logic [ADDR_W:0] sum;
    sum = {1'b0, head} + {1'b0, slot};
    if (sum >= (ADDR_W+1)'(CAPACITY)) begin
      sum = sum - (ADDR_W+1)'(CAPACITY);
    end
    return sum[ADDR_W-1:0];
  endfunction

  function automatic logic [FILL_W-1:0] fill_of(input logic [CNT_W-1:0] cnt);
    logic [FILL_W+CNT_W-1:0] wide;
    wide = {{FILL_W{1'b0}}, cnt};
    return wide[FILL_W-1:0];
  endfunction

  spq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  assign rdata    = entry_t'(rdata_raw);
  assign in_entry = '{key: in_i.sort_key, payload: in_i.payload_handle,
                      offset: in_i.item_offset};
  assign cnt_last = (cnt_q == '0) ? '0 : ADDR_W'(cnt_q - 1'b1);
  assign head_inc = (head_q == ADDR_W'(CAPACITY - 1)) ? '0 : head_q + 1'b1;
  assign cnt_inc  = cnt_q + 1'b1;
  assign cnt_dec  = cnt_q - 1'b1;
  // the one key comparator, shared by every step of the insert scan
  assign key_less = rdata.key < new_q.key;

  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    new_d   = new_q;
    res_d   = res_q;
    out_d   = out_q;
    oval_d  = oval_q;
    we      = 1'b0;
    waddr   = phys(head_q, '0);
    wdata   = new_q;
    raddr   = head_q;

    if (out_o.ready) begin
      oval_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        raddr = (in_i.func == FUNC_DEQUEUE) ? head_q : phys(head_q, cnt_last);
        if (in_i.valid) begin
          res_d   = '0;
          state_d = S_RESP;
          new_d   = in_entry;
          if (in_i.func == FUNC_DEQUEUE) begin
            if (cnt_q == '0) begin
              res_d.status = STATUS_EMPTY;
            end else begin
              state_d = S_DEQ;
            end
            res_d.fill_count = fill_of(cnt_q);
          end else if (cnt_q == CNT_W'(CAPACITY)) begin
            res_d.status     = STATUS_FULL;
            res_d.fill_count = fill_of(cnt_q);
          end else if (cnt_q == '0) begin
            we               = 1'b1;
            waddr            = head_q;
            wdata            = in_entry;
            cnt_d            = cnt_inc;
            res_d.fill_count = fill_of(cnt_inc);
          end else begin
            idx_d   = cnt_last;
            state_d = S_INS_CMP;
          end
        end
      end

      S_INS_CMP: begin
        raddr = phys(head_q, (idx_q == '0) ? '0 : idx_q - 1'b1);
        we    = 1'b1;
        waddr = phys(head_q, idx_q + 1'b1);
        if (key_less) begin
          wdata            = new_q;
          cnt_d            = cnt_inc;
          res_d.fill_count = fill_of(cnt_inc);
          state_d          = S_RESP;
        end else begin
          // move this entry up one slot and keep scanning toward the head
          wdata = rdata;
          if (idx_q == '0) begin
            state_d = S_INS_PUT;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end

      S_INS_PUT: begin
        we               = 1'b1;
        waddr            = head_q;
        wdata            = new_q;
        cnt_d            = cnt_inc;
        res_d.fill_count = fill_of(cnt_inc);
        state_d          = S_RESP;
      end

      S_DEQ: begin
        res_d.out_valid   = 1'b1;
        res_d.out_key     = rdata.key;
        res_d.out_payload = rdata.payload;
        res_d.out_offset  = rdata.offset;
        res_d.status      = STATUS_OK;
        res_d.fill_count  = fill_of(cnt_dec);
        head_d            = head_inc;
        cnt_d             = cnt_dec;
        state_d           = S_RESP;
      end

      S_RESP: begin
        if (!oval_q || out_o.ready) begin
          out_d   = res_q;
          oval_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    new_q <= new_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_o.valid       = oval_q;
  assign out_o.out_valid   = out_q.out_valid;
  assign out_o.out_key     = out_q.out_key;
  assign out_o.out_payload = out_q.out_payload;
  assign out_o.out_offset  = out_q.out_offset;
  assign out_o.status      = out_q.status;
  assign out_o.fill_count  = out_q.fill_count;

endmodule

`default_nettype wire

// File: hdl/spq_chk.sv
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_unit.
`default_nettype none

module spq_chk (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  input  wire logic                             in_ready_i,
  input  wire logic                             out_vld_i,
  input  wire logic                             out_rdy_i,
  input  wire logic                             res_valid_i,
  input  wire logic signed [spq_pkg::KEY_W-1:0] res_key_i,
  input  wire logic [spq_pkg::HANDLE_W-1:0]     res_payload_i,
  input  wire logic [spq_pkg::OFFSET_W-1:0]     res_offset_i,
  input  wire logic [spq_pkg::STATUS_W-1:0]     status_i,
  input  wire logic [spq_pkg::FILL_W-1:0]       fill_count_i
);

  import spq_pkg::*;

  // a stalled result holds its valid, entry flag, key, status and fill count
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_i && !out_rdy_i |=> out_vld_i && $stable(res_key_i) && $stable(status_i)
      && $stable(fill_count_i) && $stable(res_valid_i))
    else $error("stalled result changed");

  // one request at a time: busy right after a request is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while busy");

  a_entry_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_i && res_valid_i |-> status_i == STATUS_OK)
    else $error("returned entry with error status");

  a_empty_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_i && status_i == STATUS_EMPTY |-> fill_count_i == '0 && !res_valid_i)
    else $error("empty dequeue with nonzero fill");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_i && !res_valid_i |-> res_key_i == '0 && res_payload_i == '0
      && res_offset_i == '0)
    else $error("fields nonzero without an entry");

endmodule

bind sorted_priority_queue_unit spq_chk u_spq_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_vld_i     (out_o.valid),
  .out_rdy_i     (out_o.ready),
  .res_valid_i   (out_o.out_valid),
  .res_key_i     (out_o.out_key),
  .res_payload_i (out_o.out_payload),
  .res_offset_i  (out_o.out_offset),
  .status_i      (out_o.status),
  .fill_count_i  (out_o.fill_count)
);

`default_nettype wire

// File: verif/tb_sorted_priority_queue_unit.sv
`timescale 1ns / 100ps
// Testbench for sorted_priority_queue_unit: directed and random insert/dequeue requests,
// each result checked against a sorted-list model kept in the bench.
// Depends on spq_pkg, spq_if and the RTL of the queue.

module tb_sorted_priority_queue_unit;
  import spq_pkg::*;

  localparam int unsigned DEPTH          = CAPACITY_DEF;
  localparam int unsigned PHASES         = 14;
  localparam int unsigned PHASE_ITEMS    = 100;
  localparam int unsigned TAIL_ITEMS     = 150;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned HOLD_AT_FIRST  = 120;
  localparam int unsigned HOLD_AT_SECOND = 900;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam longint unsigned LIMIT_NS   = 3_000_000;

  typedef struct {
    func_e                   func;
    logic signed [KEY_W-1:0] key;
    logic [HANDLE_W-1:0]     payload;
    logic [OFFSET_W-1:0]     offset;
    bit                      after_drain;  // hold this request until all results are in
  } request_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  spq_in_if  in_if ();
  spq_out_if out_if ();

  sorted_priority_queue_unit #(
    .CAPACITY(DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  request_t    request_queue[$];
  result_t     due_results[$];
  entry_t      model_entries[DEPTH];
  int unsigned model_count  = 0;
  int unsigned accepted_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned send_gap     = 0;
  int unsigned recv_gap     = 0;
  int unsigned hold_left    = 0;
  int unsigned holds_done   = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Sorted-list model: updates the bench copy of the queue and queues the expected result.
  function automatic void predict_queue_result(request_t req);
    result_t     res;
    int unsigned pos;
    res = '0;
    if (req.func == FUNC_INSERT) begin
      if (model_count >= DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        pos = 0;
        while (pos < model_count && $signed(model_entries[pos].key) < $signed(req.key))
          pos++;
        for (int unsigned i = model_count; i > pos; i--)
          model_entries[i] = model_entries[i-1];
        model_entries[pos] = '{key: req.key, payload: req.payload, offset: req.offset};
        model_count++;
      end
    end else if (model_count == 0) begin
      res.status = STATUS_EMPTY;
    end else begin
      res.out_valid   = 1'b1;
      res.out_key     = model_entries[0].key;
      res.out_payload = model_entries[0].payload;
      res.out_offset  = model_entries[0].offset;
      for (int unsigned i = 1; i < model_count; i++)
        model_entries[i-1] = model_entries[i];
      model_count--;
    end
    res.fill_count = model_count[FILL_W-1:0];
    due_results.push_back(res);
  endfunction

  function automatic void check_field(string name, logic [KEY_W-1:0] want,
                                      logic [KEY_W-1:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endfunction

  function automatic void add_request(func_e f, logic signed [KEY_W-1:0] k,
                                      logic [HANDLE_W-1:0] p, logic [OFFSET_W-1:0] o,
                                      bit drain);
    request_queue.push_back('{func: f, key: k, payload: p, offset: o, after_drain: drain});
  endfunction

  // Small range gives many equal keys; extremes hit the signed compare edges.
  function automatic logic signed [KEY_W-1:0] random_key();
    case ($urandom_range(0, 3))
      0: return KEY_W'($urandom_range(0, 8) - 4);
      1: begin
        case ($urandom_range(0, 3))
          0: return {1'b1, {(KEY_W-1){1'b0}}};
          1: return {1'b0, {(KEY_W-1){1'b1}}};
          2: return '0;
          default: return '1;
        endcase
      end
      default: return KEY_W'($urandom);
    endcase
  endfunction

  // Idling off near the end and in every fourth stretch of the run.
  function automatic bit idling_on();
    return request_queue.size() > TAIL_ITEMS && (request_queue.size() / 120) % 4 != 3;
  endfunction

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin : driver_proc
    request_t nxt;
    bit       offer;
    if (!rst_ni) begin
      in_if.valid          <= 1'b0;
      in_if.func           <= FUNC_INSERT;
      in_if.sort_key       <= '0;
      in_if.payload_handle <= '0;
      in_if.item_offset    <= '0;
      send_gap = 0;
    end else begin
      offer = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        predict_queue_result(request_queue.pop_front());
        accepted_cnt <= accepted_cnt + 1;
        offer = 1'b0;
      end
      if (!offer) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (idling_on() && $urandom_range(0, 4) == 0) begin
          send_gap = $urandom_range(0, 4);
        end else if (request_queue.size() != 0 &&
                     (!request_queue[0].after_drain || due_results.size() == 0)) begin
          nxt = request_queue[0];
          offer = 1'b1;
          in_if.func           <= nxt.func;
          in_if.sort_key       <= nxt.key;
          in_if.payload_handle <= nxt.payload;
          in_if.item_offset    <= nxt.offset;
        end
        in_if.valid <= offer;
      end
    end
  end

  // Long receiver hold-off so the block backs up and stalls its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 &&
                 accepted_cnt >= (holds_done == 0 ? HOLD_AT_FIRST : HOLD_AT_SECOND)) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // Result monitor
  always @(posedge clk_i or negedge rst_ni) begin : monitor_proc
    result_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (due_results.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: expected no result, got key %h payload %h offset %h status %h",
                   $time, out_if.out_key, out_if.out_payload, out_if.out_offset,
                   out_if.status);
        end else begin
          want = due_results.pop_front();
          check_field("out_valid", want.out_valid, out_if.out_valid);
          check_field("out_key", want.out_key, out_if.out_key);
          check_field("out_payload", want.out_payload, out_if.out_payload);
          check_field("out_offset", want.out_offset, out_if.out_offset);
          check_field("status", want.status, out_if.status);
          check_field("fill_count", want.fill_count, out_if.fill_count);
        end
      end
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        out_if.ready <= 1'b0;
      end else if (idling_on() && $urandom_range(0, 5) == 0) begin
        recv_gap = $urandom_range(0, 4);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned bias_pct [7];
    int unsigned bias;
    bias_pct = '{90, 10, 70, 30, 50, 97, 3};

    in_if.valid          = 1'b0;
    in_if.func           = FUNC_INSERT;
    in_if.sort_key       = '0;
    in_if.payload_handle = '0;
    in_if.item_offset    = '0;
    out_if.ready         = 1'b0;

    // directed: empty dequeue, key extremes, equal keys, fill up, full insert
    add_request(FUNC_DEQUEUE, '0, '0, '0, 1'b0);
    add_request(FUNC_INSERT, 32'sh7FFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    add_request(FUNC_INSERT, 32'sh8000_0000, 16'h0000, 16'h0000, 1'b0);
    add_request(FUNC_INSERT, '0, 16'h1111, 16'h2222, 1'b0);
    add_request(FUNC_INSERT, '0, 16'h3333, 16'h4444, 1'b0);  // newer equal key goes first
    add_request(FUNC_INSERT, -1, 16'hA5A5, 16'h5A5A, 1'b0);
    add_request(FUNC_DEQUEUE, '1, 16'hFFFF, 16'hFFFF, 1'b0);
    add_request(FUNC_DEQUEUE, '0, '0, '0, 1'b0);
    for (int i = 0; i < 13; i++)
      add_request(FUNC_INSERT, KEY_W'(i * 7 - 40), HANDLE_W'(i), OFFSET_W'(~i), 1'b0);
    add_request(FUNC_INSERT, -5, 16'hBEEF, 16'hCAFE, 1'b0);  // queue full: dropped

    // random phases with a shifting insert bias; each phase starts on an empty pipe
    for (int ph = 0; ph < PHASES; ph++) begin
      bias = bias_pct[ph % 7];
      for (int n = 0; n < PHASE_ITEMS; n++)
        add_request($urandom_range(0, 99) < bias ? FUNC_INSERT : FUNC_DEQUEUE,
                    random_key(), HANDLE_W'($urandom), OFFSET_W'($urandom), n == 0);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_queue.size() != 0 || due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule
